// ===== rtl/psl_pkg.sv =====
// Package for the PLL synthesizer word-serial loader.
// Holds the sequence constants, field widths, codes and state types.
// No dependencies.
`timescale 1ns / 1ps

package psl_pkg;

  // Number of clocked data bits in one loading sequence
  localparam int SERIAL_BITS = 28;

  localparam int STEP_W = 7;
  localparam int FREQ_W = 22;
  localparam int DIVR_W = 17;
  localparam int CNT_W  = 5;
  localparam int DIV_STEPS = FREQ_W;

  // Index of the "enable low" action; one past it comes the stop action
  localparam logic [STEP_W-1:0] LOOP_END = STEP_W'(5 + 3 * SERIAL_BITS);

  // Pin byte layout
  localparam int PIN_DATA = 0;
  localparam int PIN_CLK  = 1;
  localparam int PIN_EN   = 2;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_COMP_STEP = 2'd0,
    REG_PRESCALER = 2'd1,
    REG_REF_OSC   = 2'd2,
    REG_EXP_ADDR  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_RESP = 2'd2
  } state_t;

  // Which quotient the shared divider is working on
  typedef enum logic [1:0] {
    DV_N = 2'd0,
    DV_M = 2'd1,
    DV_R = 2'd2
  } div_phase_t;

  // Clock-phase position inside one data bit round
  typedef enum logic [1:0] {
    PH_CLK_UP   = 2'd0,
    PH_DATA     = 2'd1,
    PH_CLK_DOWN = 2'd2
  } bit_phase_t;

endpackage

// ===== rtl/pll_synth_word_serial_loader.sv =====
// Top level of the PLL synthesizer word-serial loader.
// Timing: a tick transaction is answered in the output register in the cycle after it is
// accepted; a load taken while no sequence is active runs the shared divider three times.
// Throughput: one item at a time; a new item is taken only once the last result is accepted,
// and a load is paced by the single restoring divider that resolves one quotient bit per cycle.
// Reset: synchronous, active low; clears the sequencer, the loader state and the registers.
`timescale 1ns / 1ps

module pll_synth_word_serial_loader
  import psl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [21:0] frequency_khz, [23:22] zero
  input  logic        in_tuser,   // [0] kind
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] byte_value, [8] busy_res, [9] range_error
  output logic [1:0]  out_tuser,  // [1:0] action
  output logic        out_tlast,  // last
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] comp_step_r;
  logic [6:0]  prescaler_r;
  logic [21:0] ref_osc_r;
  logic [7:0]  exp_addr_r;

  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_step_r <= 16'd10;
      prescaler_r <= 7'd64;
      ref_osc_r   <= 22'd10000;
      exp_addr_r  <= 8'd64;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COMP_STEP: comp_step_r <= pwdata[15:0];
        REG_PRESCALER: prescaler_r <= pwdata[6:0];
        REG_REF_OSC:   ref_osc_r   <= pwdata[21:0];
        REG_EXP_ADDR:  exp_addr_r  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_COMP_STEP: prdata = {16'd0, comp_step_r};
      REG_PRESCALER: prdata = {25'd0, prescaler_r};
      REG_REF_OSC:   prdata = {10'd0, ref_osc_r};
      REG_EXP_ADDR:  prdata = {24'd0, exp_addr_r};
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic  in_acc;
  kind_t in_kind;
  logic  active_r, active_nxt;
  logic  div_done;

  div_phase_t dph_r, dph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_acc  = in_tvalid & in_tready;
  assign in_kind = kind_t'(in_tuser);
  // Last quotient bit of the reference divider ends the load
  assign div_done = (cnt_r == CNT_W'(DIV_STEPS - 1)) && (dph_r == DV_R);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_LOAD && !active_r) state_nxt = ST_DIV;
          else                                   state_nxt = ST_RESP;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_RESP);
  end

  // ---------------------------------------------------------------------
  // Shared restoring divider: one quotient bit per cycle. The dividend
  // shifts out of the top of q_r while quotient bits enter at the bottom.
  // A zero divisor always passes the trial subtraction, so the quotient comes out all ones and
  // the remainder equals the dividend.
  // ---------------------------------------------------------------------
  logic [FREQ_W-1:0] q_r, q_nxt;
  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] divisor;
  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   trial_sub;
  logic              qbit;
  logic [FREQ_W-1:0] step_q;
  logic [FREQ_W-1:0] step_rem;

  always_comb begin
    unique case (dph_r)
      DV_N:    divisor = {1'b0, comp_step_r};
      DV_M:    divisor = {10'd0, prescaler_r};
      DV_R:    divisor = {comp_step_r, 1'b0};
      default: divisor = {1'b0, comp_step_r};
    endcase
    trial     = {rem_r, q_r[FREQ_W-1]};
    trial_sub = trial - {(FREQ_W + 1 - DIVR_W)'(0), divisor};
    qbit      = (trial >= {(FREQ_W + 1 - DIVR_W)'(0), divisor});
    step_rem  = qbit ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
    step_q    = {q_r[FREQ_W-2:0], qbit};
  end

  // ---------------------------------------------------------------------
  // Loader state and result register
  // ---------------------------------------------------------------------
  logic [31:0] shift_r, shift_nxt;
  logic [7:0]  pin_r, pin_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic        err_r, err_nxt;
  bit_phase_t  bph_r, bph_nxt;

  // Partial results of a load
  logic [6:0]  a_r, a_nxt;
  logic [9:0]  m_r, m_nxt;
  logic        err_am_r, err_am_nxt;

  action_t     out_act_r, out_act_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_busy_r, out_busy_nxt;
  logic        out_err_r, out_err_nxt;
  logic        out_last_r, out_last_nxt;

  always_comb begin
    shift_nxt    = shift_r;
    pin_nxt      = pin_r;
    step_nxt     = step_r;
    err_nxt      = err_r;
    bph_nxt      = bph_r;
    active_nxt   = active_r;
    a_nxt        = a_r;
    m_nxt        = m_r;
    err_am_nxt   = err_am_r;
    dph_nxt      = dph_r;
    cnt_nxt      = cnt_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    out_act_nxt  = out_act_r;
    out_byte_nxt = out_byte_r;
    out_busy_nxt = out_busy_r;
    out_err_nxt  = out_err_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // Default answer: nothing on the bus
          out_act_nxt  = ACT_NONE;
          out_byte_nxt = 8'd0;
          out_last_nxt = 1'b0;
          out_busy_nxt = active_r;
          out_err_nxt  = err_r;
          if (in_kind == KIND_LOAD) begin
            // Start the first division; a load while busy is dropped
            dph_nxt = DV_N;
            cnt_nxt = '0;
            q_nxt   = in_tdata[FREQ_W-1:0];
            rem_nxt = '0;
          end else if (active_r) begin
            out_act_nxt = ACT_WRITE;
            if (step_r == STEP_W'(0)) begin
              out_act_nxt = ACT_START;
            end else if (step_r == STEP_W'(1)) begin
              out_byte_nxt = exp_addr_r;
            end else if (step_r == STEP_W'(2)) begin
              pin_nxt[PIN_DATA] = shift_r[31];
              shift_nxt         = {shift_r[30:0], 1'b0};
              out_byte_nxt      = pin_nxt;
            end else if (step_r == STEP_W'(3)) begin
              pin_nxt[PIN_CLK] = 1'b1;
              out_byte_nxt     = pin_nxt;
            end else if (step_r == STEP_W'(4)) begin
              pin_nxt[PIN_EN] = 1'b1;
              out_byte_nxt    = pin_nxt;
            end else if (step_r < LOOP_END) begin
              unique case (bph_r)
                PH_CLK_UP: begin
                  pin_nxt[PIN_CLK] = 1'b1;
                  bph_nxt          = PH_DATA;
                end
                PH_DATA: begin
                  pin_nxt[PIN_DATA] = shift_r[31];
                  shift_nxt         = {shift_r[30:0], 1'b0};
                  bph_nxt           = PH_CLK_DOWN;
                end
                default: begin
                  pin_nxt[PIN_CLK] = 1'b0;
                  bph_nxt          = PH_CLK_UP;
                end
              endcase
              out_byte_nxt = pin_nxt;
            end else if (step_r == LOOP_END) begin
              pin_nxt[PIN_EN] = 1'b0;
              out_byte_nxt    = pin_nxt;
            end else begin
              out_act_nxt  = ACT_STOP;
              out_last_nxt = 1'b1;
              active_nxt   = 1'b0;
              out_busy_nxt = 1'b0;
            end
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end

      ST_DIV: begin
        q_nxt   = step_q;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          unique case (dph_r)
            DV_N: begin
              // N stays in q_r as the next dividend
              dph_nxt = DV_M;
            end
            DV_M: begin
              a_nxt      = step_rem[6:0];
              m_nxt      = step_q[9:0];
              err_am_nxt = (|step_rem[FREQ_W-1:7]) | (|step_q[FREQ_W-1:10]);
              dph_nxt    = DV_R;
              q_nxt      = ref_osc_r;
            end
            default: begin
              err_nxt      = err_am_r | (|step_q[FREQ_W-1:11]);
              shift_nxt    = {a_r, m_r, step_q[10:0], 4'd0};
              pin_nxt      = 8'd0;
              step_nxt     = '0;
              bph_nxt      = PH_CLK_UP;
              active_nxt   = 1'b1;
              out_act_nxt  = ACT_NONE;
              out_byte_nxt = 8'd0;
              out_busy_nxt = 1'b1;
              out_err_nxt  = err_nxt;
              out_last_nxt = 1'b0;
            end
          endcase
        end
      end

      default: begin
        // Hold the result until the sink takes it
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
      shift_r  <= '0;
      pin_r    <= '0;
      step_r   <= '0;
      err_r    <= 1'b0;
      bph_r    <= PH_CLK_UP;
      dph_r    <= DV_N;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      shift_r  <= shift_nxt;
      pin_r    <= pin_nxt;
      step_r   <= step_nxt;
      err_r    <= err_nxt;
      bph_r    <= bph_nxt;
      dph_r    <= dph_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    a_r        <= a_nxt;
    m_r        <= m_nxt;
    err_am_r   <= err_am_nxt;
    out_act_r  <= out_act_nxt;
    out_byte_r <= out_byte_nxt;
    out_busy_r <= out_busy_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tdata = {6'd0, out_err_r, out_busy_r, out_byte_r};
  assign out_tuser = out_act_r;
  assign out_tlast = out_last_r;

endmodule

// ===== tb/pll_synth_word_serial_loader_checker.sv =====
// Checker for the PLL synthesizer word-serial loader: watches the register port and both
// streams, predicts each result transaction and compares it field by field.
// Depends on psl_pkg for the action, kind, register and pin constants.
`timescale 1ns / 1ps

module pll_synth_word_serial_loader_checker
  import psl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [21:0] frequency_khz, [23:22] zero
  input  logic        in_tuser,   // [0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] byte_value, [8] busy_res, [9] range_error
  input  logic [1:0]  out_tuser,  // [1:0] action
  input  logic        out_tlast,  // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          sequences_done,
  output int          overrange_loads
);

  localparam logic [31:0] QUOT_ALL_ONES = 32'h003F_FFFF;
  localparam int          REPORT_CAP    = 40;

  typedef struct packed {
    action_t    action;
    logic [7:0] pin_val;
    logic       busy;
    logic       range_err;
    logic       stop;
  } bus_result_t;

  // Register images
  logic [15:0] step_khz;
  logic [6:0]  modulus;
  logic [21:0] ref_khz;
  logic [7:0]  exp_addr;

  // Loader state
  logic [31:0]       shift_word;
  logic [7:0]        pins;
  logic [STEP_W-1:0] step_idx;
  logic              seq_on;
  logic              err_flag;

  bus_result_t bus_actions_due[$];
  int          reported;

  task automatic report_error(input string msg);
    if (reported < REPORT_CAP) $display("[%0t] checker: %s", $realtime, msg);
    reported++;
    mismatches++;
  endtask

  function automatic void shift_data_pin();
    pins[PIN_DATA] = shift_word[31];
    shift_word     = shift_word << 1;
  endfunction

  // Advance the predicted loader by one input transaction and return its result
  function automatic bus_result_t loader_step(input kind_t kind, input logic [21:0] freq);
    bus_result_t res;
    logic [31:0] n, a, m, r, dv;
    bit_phase_t  ph;
    res = '{action: ACT_NONE, pin_val: 8'h00, busy: 1'b0, range_err: 1'b0, stop: 1'b0};
    if (kind == KIND_LOAD) begin
      if (!seq_on) begin
        // Zero divisors behave like a restoring divider: all-ones quotient
        n  = (step_khz == 16'd0) ? QUOT_ALL_ONES : 32'(freq) / 32'(step_khz);
        a  = (modulus == 7'd0) ? n : n % 32'(modulus);
        m  = (modulus == 7'd0) ? QUOT_ALL_ONES : n / 32'(modulus);
        dv = 32'(step_khz) << 1;
        r  = (dv == 32'd0) ? QUOT_ALL_ONES : 32'(ref_khz) / dv;
        err_flag   = (a > 32'd127) || (m > 32'd1023) || (r > 32'd2047);
        shift_word = {a[6:0], m[9:0], r[10:0], 4'b0000};
        pins       = 8'h00;
        step_idx   = '0;
        seq_on     = 1'b1;
        if (err_flag) overrange_loads++;
      end
    end else if (seq_on) begin
      res.action = ACT_WRITE;
      if (step_idx == 0) begin
        res.action = ACT_START;
      end else if (step_idx == 1) begin
        res.pin_val = exp_addr;
      end else if (step_idx == 2) begin
        shift_data_pin();
        res.pin_val = pins;
      end else if (step_idx == 3) begin
        pins[PIN_CLK] = 1'b1;
        res.pin_val = pins;
      end else if (step_idx == 4) begin
        pins[PIN_EN] = 1'b1;
        res.pin_val = pins;
      end else if (step_idx < LOOP_END) begin
        ph = bit_phase_t'((step_idx - 5) % 3);
        case (ph)
          PH_CLK_UP: pins[PIN_CLK] = 1'b1;
          PH_DATA:   shift_data_pin();
          default:   pins[PIN_CLK] = 1'b0;
        endcase
        res.pin_val = pins;
      end else if (step_idx == LOOP_END) begin
        pins[PIN_EN] = 1'b0;
        res.pin_val = pins;
      end else begin
        res.action = ACT_STOP;
        res.stop   = 1'b1;
        seq_on     = 1'b0;
        sequences_done++;
      end
      step_idx = step_idx + 1'b1;
    end
    res.busy      = seq_on;
    res.range_err = err_flag;
    return res;
  endfunction

  always @(posedge clk) begin
    bus_result_t want;
    if (!rst_n) begin
      step_khz   = 16'd10;
      modulus    = 7'd64;
      ref_khz    = 22'd10000;
      exp_addr   = 8'd64;
      shift_word = '0;
      pins       = '0;
      step_idx   = '0;
      seq_on     = 1'b0;
      err_flag   = 1'b0;
      bus_actions_due.delete();
      reported        = 0;
      mismatches      = 0;
      sequences_done  = 0;
      overrange_loads = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_COMP_STEP: step_khz = pwdata[15:0];
          REG_PRESCALER: modulus  = pwdata[6:0];
          REG_REF_OSC:   ref_khz  = pwdata[21:0];
          REG_EXP_ADDR:  exp_addr = pwdata[7:0];
          default: ;
        endcase
      end
      // Compare first: a result at this edge can never belong to an input at this edge
      if (out_tvalid && out_tready) begin
        if (bus_actions_due.size() == 0) begin
          report_error("result transaction with no expectation waiting");
        end else begin
          want = bus_actions_due.pop_front();
          if (out_tuser !== want.action)
            report_error($sformatf("action got %0d expected %0d", out_tuser, want.action));
          if (out_tdata[7:0] !== want.pin_val)
            report_error($sformatf("byte_value got %02h expected %02h",
                                   out_tdata[7:0], want.pin_val));
          if (out_tdata[8] !== want.busy)
            report_error($sformatf("busy_res got %b expected %b", out_tdata[8], want.busy));
          if (out_tdata[9] !== want.range_err)
            report_error($sformatf("range_error got %b expected %b",
                                   out_tdata[9], want.range_err));
          if (out_tlast !== want.stop)
            report_error($sformatf("last got %b expected %b", out_tlast, want.stop));
        end
      end
      if (in_tvalid && in_tready)
        bus_actions_due.push_back(loader_step(kind_t'(in_tuser), in_tdata[21:0]));
    end
    pending <= bus_actions_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the word-serial loader testbench: clock, reset, register writes, stimulus and
// verdict. Depends on psl_pkg, the loader RTL and pll_synth_word_serial_loader_checker.
`timescale 1ns / 1ps

module tb
  import psl_pkg::*;
();

  // Wait longer than a load occupies the divider before register writes
  localparam int SETTLE_CYCLES = 90;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SEQ_LEN       = 7 + 3 * SERIAL_BITS;
  localparam int PHASE_ITEMS   = 90;
  localparam int NUM_PHASES    = 8;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [21:0] frequency_khz, [23:22] zero
  logic        in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // [7:0] byte_value, [8] busy_res, [9] range_error
  logic [1:0]  out_tuser;  // [1:0] action
  logic        out_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int sequences_done;
  int overrange_loads;

  // Stimulus bookkeeping
  int          cycles = 0;
  int          items_sent;
  int          loads_sent;
  int          reg_writes;
  bit          tx_calm;
  bit          rx_calm;
  int          rx_stall;
  int unsigned cur_step;
  int unsigned cur_pre;

  pll_synth_word_serial_loader DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  pll_synth_word_serial_loader_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .pending         (pending),
    .sequences_done  (sequences_done),
    .overrange_loads (overrange_loads)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side back-pressure: mostly short stalls, a few long ones, and calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
      rx_calm  = 1'b0;
    end else begin
      if ($urandom_range(0, 399) == 0) rx_calm = ~rx_calm;
      if (rx_stall > 0) begin
        out_tready <= 1'b0;
        rx_stall--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 25)
          rx_stall = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 35);
      end
    end
  end

  // Gap before a transaction: most none or short, a few long
  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (tx_calm || sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Frequencies: extremes, walking ones, values that land inside the packed fields, and noise
  function automatic logic [21:0] pick_frequency();
    int unsigned     sel;
    longint unsigned n;
    longint unsigned f;
    sel = $urandom_range(0, 99);
    if (sel < 6) return '0;
    if (sel < 12) return '1;
    if (sel < 20) return 22'(1) << $urandom_range(0, 21);
    if (sel < 65 && cur_step != 0 && cur_pre != 0) begin
      n = $urandom_range(0, cur_pre * 1024 - 1);
      f = n * cur_step + $urandom_range(0, cur_step - 1);
      if (f <= 64'h3F_FFFF) return 22'(f);
    end
    return 22'($urandom);
  endfunction

  // Present one transaction and hold it until accepted; keep valid high across back-to-back
  task automatic send_item(input kind_t kind, input logic [21:0] freq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, freq};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (kind == KIND_LOAD) loads_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(KIND_TICK, 22'($urandom));
  endtask

  // Drop valid and hold off until every expected result is in and the divider is quiet;
  // wait for a clock edge first so the checker's count includes the last accepted transaction
  task automatic drain_results(input int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  task automatic configure(input int unsigned step, input int unsigned pre,
                           input int unsigned ref_osc, input int unsigned addr);
    cur_step = step & 32'hFFFF;
    cur_pre  = pre & 32'h7F;
    write_reg(REG_COMP_STEP, step);
    write_reg(REG_PRESCALER, pre);
    write_reg(REG_REF_OSC, ref_osc);
    write_reg(REG_EXP_ADDR, addr);
  endtask

  // One full load-and-shift sequence with random content; now and then a stray load
  // lands mid-sequence and must be ignored
  task automatic send_sequence();
    send_item(KIND_LOAD, pick_frequency());
    for (int k = 0; k < SEQ_LEN; k++) begin
      if ($urandom_range(0, 99) < 3) send_item(KIND_LOAD, pick_frequency());
      send_item(KIND_TICK, 22'($urandom));
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_item(kind_t'($urandom_range(0, 1)), pick_frequency());
  endtask

  initial begin
    int unsigned rnd_step;
    int          phase_start;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_LOAD;
    rst_n     <= 1'b0;
    items_sent = 0;
    loads_sent = 0;
    reg_writes = 0;
    tx_calm    = 1'b0;
    cur_step   = 10;
    cur_pre    = 64;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, oversized load, ignored load while busy, full sequence, idle tick
    send_item(KIND_TICK, '0);
    send_item(KIND_LOAD, '1);
    send_item(KIND_LOAD, '0);
    send_ticks(SEQ_LEN);
    send_item(KIND_TICK, '1);
    // Smallest frequency: all-zero swallow and main counts
    send_item(KIND_LOAD, '0);
    send_ticks(SEQ_LEN);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_results(SETTLE_CYCLES);
        case (p)
          1: configure(1, 1, 32'h3F_FFFF, 8'h00);           // low extremes, huge R
          2: configure(16'hFFFF, 7'h7F, 1, 8'hFF);          // high extremes, R of zero
          3: configure(0, 0, 10000, 8'hA5);                 // zero divisors
          4: configure(25, 100, 50000, 8'h4E);              // fields in range
          5: begin
            rnd_step = $urandom_range(1, 200);
            configure(rnd_step, $urandom_range(1, 127),
                      $urandom_range(1, 4094 * rnd_step), $urandom_range(0, 255));
          end
          default: configure($urandom & 32'hFFFF, $urandom & 32'h7F,
                             $urandom & 32'h3F_FFFF, $urandom & 32'hFF);
        endcase
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 80) send_sequence();
        else send_noise();
        // Hold the sender until the result side has caught up
        if ($urandom_range(0, 99) < 15) drain_results(0);
      end
      // Enough ticks to close any open sequence, plus idle ticks past the stop
      tx_calm = 1'b0;
      send_ticks(SEQ_LEN + 2);
    end

    drain_results(SETTLE_CYCLES);
    $display("Covered %0d transactions (%0d loads, %0d out of range), %0d register writes,",
             items_sent, loads_sent, overrange_loads, reg_writes);
    $display("%0d complete bus sequences over %0d register settings.",
             sequences_done, NUM_PHASES);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== pll_synth_word_serial_loader.f =====
rtl/psl_pkg.sv
rtl/pll_synth_word_serial_loader.sv
tb/pll_synth_word_serial_loader_checker.sv
tb/tb.sv
